// File: rtl/u8u2_pkg.sv
`default_nettype none

package u8u2_pkg;

  // Byte classification masks and patterns
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContPat    = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Pat   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Pat   = 8'hE0;
  localparam logic [7:0] EndMarker  = 8'h00;

  // Payload masks
  localparam logic [7:0] Lead2Bits  = 8'h1F;
  localparam logic [7:0] Lead3Bits  = 8'h0F;
  localparam logic [7:0] ContBits   = 8'h3F;

  // Code unit emitted for the end marker
  localparam logic [15:0] SpaceUnit = 16'h0020;

  // Pending byte counts
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendLead = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  // One decoded result from the decode stage
  typedef struct packed {
    logic        valid;
    logic [15:0] code_unit;
    logic        end_of_field;
  } result_t;

  function automatic logic is_cont(input logic [7:0] b);
    is_cont = (b & ContMask) == ContPat;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_to_ucs2_decoder_core.sv
// Channel   Handshake              Payload
// input     in_valid_i/in_ready_o  text_byte_i[7:0]
// output    out_valid_o/out_ready_i code_unit_o[15:0], end_of_field_o
//
// One byte per cycle sustained while the output is not stalled; a byte passes
// the input register, then is decoded into the result register.
// Decode resolves each byte combinationally against up to two pending bytes.
// Bytes that complete nothing produce no result but leave only on a free output.
// Reset clears the pending bytes and both valid flags.
// A stalled output holds its result; the input register does not drain into
// it, so at most one further byte is taken while a result waits.
`default_nettype none

module utf8_to_ucs2_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      code_unit_o,
  output logic             end_of_field_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] byte_q;
  logic       out_free;
  logic       s1_go;
  logic       in_xfer;
  u8u2_pkg::result_t res;

  // Input register control
  assign s1_go      = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= text_byte_i;
    end
  end

  // Decode against pending bytes
  u8u2_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_q),
    .step_i (s1_go),
    .res_o  (res)
  );

  // Result register
  u8u2_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (s1_go),
    .res_i          (res),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .code_unit_o    (code_unit_o),
    .end_of_field_o (end_of_field_o),
    .free_o         (out_free)
  );

endmodule

`default_nettype wire

// File: rtl/u8u2_decode.sv
`default_nettype none

module u8u2_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        byte_i,
  input  wire logic              step_i,
  output u8u2_pkg::result_t      res_o
);

  logic [7:0] lead_q, lead_d;
  logic [7:0] cont_q, cont_d;
  logic [1:0] count_q, count_d;

  // Resolve the byte against the pending bytes
  always_comb begin
    res_o   = '0;
    lead_d  = lead_q;
    cont_d  = cont_q;
    count_d = count_q;
    if ((count_q == u8u2_pkg::PendLead) && u8u2_pkg::is_cont(byte_i)) begin
      if ((lead_q & u8u2_pkg::Lead2Mask) == u8u2_pkg::Lead2Pat) begin
        res_o.valid     = 1'b1;
        res_o.code_unit = {5'd0, lead_q[4:0], byte_i[5:0]};
        count_d         = u8u2_pkg::PendNone;
      end else begin
        cont_d  = byte_i;
        count_d = u8u2_pkg::PendTwo;
      end
    end else if ((count_q == u8u2_pkg::PendTwo) && u8u2_pkg::is_cont(byte_i)) begin
      res_o.valid     = 1'b1;
      res_o.code_unit = {lead_q[3:0], cont_q[5:0], byte_i[5:0]};
      count_d         = u8u2_pkg::PendNone;
    end else begin
      // nothing pending or broken sequence: decode as a fresh byte
      count_d = u8u2_pkg::PendNone;
      if (byte_i == u8u2_pkg::EndMarker) begin
        res_o.valid        = 1'b1;
        res_o.code_unit    = u8u2_pkg::SpaceUnit;
        res_o.end_of_field = 1'b1;
      end else if (!byte_i[7]) begin
        res_o.valid     = 1'b1;
        res_o.code_unit = {8'd0, byte_i};
      end else if (((byte_i & u8u2_pkg::Lead2Mask) == u8u2_pkg::Lead2Pat) ||
                   ((byte_i & u8u2_pkg::Lead3Mask) == u8u2_pkg::Lead3Pat)) begin
        lead_d  = byte_i;
        count_d = u8u2_pkg::PendLead;
      end
    end
  end

  // Pending state advances only when the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= '0;
      cont_q  <= '0;
      count_q <= u8u2_pkg::PendNone;
    end else if (step_i) begin
      lead_q  <= lead_d;
      cont_q  <= cont_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u8u2_out_reg.sv
`default_nettype none

module u8u2_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire u8u2_pkg::result_t res_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [15:0]            code_unit_o,
  output logic                   end_of_field_o,
  output logic                   free_o
);

  logic        valid_q, valid_d;
  logic [15:0] code_q;
  logic        eof_q;
  logic        take;

  // Register may take a new result when empty or being drained
  assign free_o = !valid_q || out_ready_i;
  assign take   = load_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      code_q <= res_i.code_unit;
      eof_q  <= res_i.end_of_field;
    end
  end

  assign out_valid_o    = valid_q;
  assign code_unit_o    = code_q;
  assign end_of_field_o = eof_q;

endmodule

`default_nettype wire

// File: rtl/u8u2_checker.sv
`default_nettype none

module u8u2_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  text_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] code_unit_o,
  input wire logic        end_of_field_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_unit_o)
      && $stable(end_of_field_o))
    else $error("stalled result changed");

  // End of field always carries the space
  a_eof_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_field_o |-> code_unit_o == 16'h0020)
    else $error("end of field without space code unit");

  // End marker reaches the output once the result register is free to take it
  a_eof_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && text_byte_i == 8'h00)
      ##1 (!out_valid_o || out_ready_i) |=> out_valid_o && end_of_field_o)
    else $error("end marker result missing");

  // Empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // No result once reset has been seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind utf8_to_ucs2_decoder_core u8u2_sva u_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .text_byte_i    (text_byte_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .code_unit_o    (code_unit_o),
  .end_of_field_o (end_of_field_o)
);

`default_nettype wire

// File: dv/u8u2_checker.sv
`timescale 1ns / 100ps

// Scoreboard for the UTF-8 to UCS-2 decoder: predicts the code unit, if any,
// that each byte transfer completes and checks every output transfer in order.
module u8u2_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_field_i,
  output int          fail_count_o,
  output int          owed_units_o
);

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } code_unit_exp_t;

  code_unit_exp_t owed_q[$];
  code_unit_exp_t head_exp;

  // Shadow decoder state
  logic [7:0] lead_byte;
  logic [7:0] mid_byte;
  logic [1:0] held_cnt;

  int fails = 0;
  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fails++;
  endtask

  // Append one expected code unit at the tail
  task automatic owe_unit(input code_unit_exp_t e);
    owed_q.insert(owed_q.size(), e);
  endtask

  // Decode one byte against the held bytes, queue the code unit it completes
  task automatic decode_byte(input logic [7:0] b);
    logic           tail;
    code_unit_exp_t e;
    tail = (b & u8u2_pkg::ContMask) == u8u2_pkg::ContPat;
    if (held_cnt == u8u2_pkg::PendLead && tail) begin
      if ((lead_byte & u8u2_pkg::Lead2Mask) == u8u2_pkg::Lead2Pat) begin
        e.unit = ({8'h00, lead_byte & u8u2_pkg::Lead2Bits} << 6)
               | {8'h00, b & u8u2_pkg::ContBits};
        e.last = 1'b0;
        owe_unit(e);
        held_cnt = u8u2_pkg::PendNone;
      end else begin
        mid_byte = b;
        held_cnt = u8u2_pkg::PendTwo;
      end
    end else if (held_cnt == u8u2_pkg::PendTwo && tail) begin
      e.unit = ({8'h00, lead_byte & u8u2_pkg::Lead3Bits} << 12)
             | ({8'h00, mid_byte & u8u2_pkg::ContBits} << 6)
             | {8'h00, b & u8u2_pkg::ContBits};
      e.last = 1'b0;
      owe_unit(e);
      held_cnt = u8u2_pkg::PendNone;
    end else begin
      // nothing held, or the held sequence is broken: drop it, start over
      held_cnt = u8u2_pkg::PendNone;
      if (b == u8u2_pkg::EndMarker) begin
        e.unit = u8u2_pkg::SpaceUnit;
        e.last = 1'b1;
        owe_unit(e);
      end else if (!b[7]) begin
        e.unit = {8'h00, b};
        e.last = 1'b0;
        owe_unit(e);
      end else if ((b & u8u2_pkg::Lead2Mask) == u8u2_pkg::Lead2Pat ||
                   (b & u8u2_pkg::Lead3Mask) == u8u2_pkg::Lead3Pat) begin
        lead_byte = b;
        held_cnt  = u8u2_pkg::PendLead;
      end
    end
  endtask

  // Output transfers are checked before the same edge's input transfer is decoded
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt  = u8u2_pkg::PendNone;
      lead_byte = '0;
      mid_byte  = '0;
      owed_q.delete();
      owed_units_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected code unit %04h last %0b",
                                    code_unit_i, end_of_field_i));
        end else begin
          head_exp = owed_q.pop_front();
          if (code_unit_i !== head_exp.unit)
            report_mismatch($sformatf("code unit %04h, want %04h",
                                      code_unit_i, head_exp.unit));
          if (end_of_field_i !== head_exp.last)
            report_mismatch($sformatf("end_of_field %0b, want %0b (unit %04h)",
                                      end_of_field_i, head_exp.last, head_exp.unit));
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(text_byte_i);
      owed_units_o <= owed_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int RandomBytes = 1700;
  localparam int QuietLimit  = 5000;
  localparam int SettleCycles = 8;

  logic        clk_i        = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte    = 8'h00;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [15:0] code_unit;
  logic        end_of_field;

  int fail_count;
  int owed_units;
  int sent_bytes  = 0;
  int burst_left  = 0;
  int quiet_cycles = 0;
  int stall_left  = 0;
  int stall_mode  = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  utf8_to_ucs2_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .text_byte_i   (text_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .code_unit_o   (code_unit),
    .end_of_field_o(end_of_field)
  );

  u8u2_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .text_byte_i   (text_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .code_unit_i   (code_unit),
    .end_of_field_i(end_of_field),
    .fail_count_o  (fail_count),
    .owed_units_o  (owed_units)
  );

  // Receiver backpressure: always ready, coin flip, or mostly stalled
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One byte transfer; a gap may open when the current burst is used up
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_bytes++;
  endtask

  // Hold off the sender until every predicted code unit has come out
  task automatic drain_units();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    do @(posedge clk_i); while (owed_units != 0);
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Any byte that is not a continuation byte
  function automatic logic [7:0] rand_non_cont();
    int r;
    r = $urandom_range(0, 191);
    if (r >= 128) r += 64;
    return 8'(r);
  endfunction

  initial begin
    int         pick;
    int         target;
    logic [7:0] lead;
    logic       drained;

    drained = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // ASCII extremes and a bare end marker
    push_byte(8'h01); push_byte(8'h7F); push_byte(8'h00);
    // two-byte: common and largest
    push_byte(8'hC2); push_byte(8'hA9);
    push_byte(8'hDF); push_byte(8'hBF);
    // three-byte: common, largest, a surrogate
    push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
    push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);
    // stray continuation, a four-byte lead and an FF byte
    push_byte(8'h80); push_byte(8'hF0); push_byte(8'hFF);
    // broken two-byte, broken three-byte in second and third place
    push_byte(8'hC3); push_byte(8'h41);
    push_byte(8'hE4); push_byte(8'h41);
    push_byte(8'hE5); push_byte(8'h80); push_byte(8'h7E);
    // end marker with a lead held
    push_byte(8'hC3); push_byte(8'h00);

    drain_units();

    // Random part: mostly well-formed sequences, some noise and broken ones
    target = sent_bytes + RandomBytes;
    while (sent_bytes < target) begin
      if (!drained && sent_bytes > target - RandomBytes / 2) begin
        drain_units();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push_byte(8'($urandom_range(1, 127)));
      end else if (pick < 55) begin
        push_byte(8'hC0 | 8'($urandom_range(0, 31)));
        push_byte(rand_cont());
      end else if (pick < 80) begin
        push_byte(8'hE0 | 8'($urandom_range(0, 15)));
        push_byte(rand_cont());
        push_byte(rand_cont());
      end else if (pick < 85) begin
        push_byte(8'h00);
      end else if (pick < 93) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        lead = 8'($urandom_range(8'hC0, 8'hEF));
        push_byte(lead);
        if (lead[5] && $urandom_range(0, 1)) push_byte(rand_cont());
        push_byte(rand_non_cont());
      end
    end

    // Wait for the last code units, then let the pipeline settle
    drain_units();
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0 && owed_units == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/u8u2_pkg.sv
rtl/u8u2_decode.sv
rtl/u8u2_out_reg.sv
rtl/utf8_to_ucs2_decoder_core.sv
rtl/u8u2_checker.sv
dv/u8u2_checker.sv
dv/tb_top.sv
